// ----- rtl/core/tcw_pkg.sv -----
// Shared constants, types and address helpers for the text console writer.
// Depends on nothing; imported by text_console_writer_core.
`default_nettype none

package tcw_pkg;

   localparam int COLS   = 80;
   localparam int ROWS   = 25;
   localparam int CELLS  = ROWS * COLS;

   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int CELL_W = CHAR_W + ATTR_W;
   localparam int ADDR_W = $clog2(CELLS);

   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;

   localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0f;
   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0a;

   typedef enum logic [REQ_USER_W-1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   // Request payload, last field in the lowest bits.
   typedef struct packed {
      logic [3:0]        pad;
      logic [COL_W-1:0]  cell_col;
      logic [ROW_W-1:0]  cell_row;
      logic [CHAR_W-1:0] char_code;
   } req_type;

   // Response payload, last field in the lowest bits.
   typedef struct packed {
      logic [2:0]        pad;
      logic [ATTR_W-1:0] read_attr;
      logic [CHAR_W-1:0] read_char;
      logic              did_scroll;
      logic [ROW_W-1:0]  cursor_row;
      logic [COL_W-1:0]  cursor_col;
   } rsp_type;

   // Map a screen row onto a memory row through the scroll offset.
   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] line,
                                                 input logic [ROW_W-1:0] top);
      logic [ROW_W:0] sum;
      sum = {1'b0, line} + {1'b0, top};
      if (sum >= (ROW_W+1)'(ROWS)) begin
         sum = sum - (ROW_W+1)'(ROWS);
      end
      return sum[ROW_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(prow) * ADDR_W'(COLS) + ADDR_W'(col);
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/text_console_writer_core.sv -----
// Text console writer: screen memory, cursor, scroll and clear sequencer.
// Depends on tcw_pkg for geometry, payload layouts and address helpers.
// Responses: put-char, unused op and out-of-range read load the response register at the
//   transfer; a cell read first passes rd_data_ff and ST_READ, scroll and clear ST_SWEEP.
// Throughput: one item per cycle for plain characters while rsp_tready stays high; the
//   scroll and clear sweeps go through the single write port, blanking one cell per cycle.
// Reset: cursor and scroll offset go to zero, attribute to 0x0f; a clearing pass over all
//   CELLS (2000) cells then fills the screen memory with blanks, req_tready held low.
`default_nettype none

module text_console_writer_core
   import tcw_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // tdata, from bit 0: char_code[7:0], cell_row[4:0], cell_col[6:0], zero fill
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: op[1:0]
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   // Response channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tdata, from bit 0: cursor_col[6:0], cursor_row[4:0], did_scroll,
   //   read_char[7:0], read_attr[7:0], zero fill
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // Attribute register
   input  wire logic                  csr_wr_en,
   input  wire logic [ATTR_W-1:0]     csr_wr_data
);

   typedef enum logic [3:0] {
      ST_INIT  = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_READ  = 4'b0100,
      ST_SWEEP = 4'b1000
   } state_type;

   // Screen memory: character in the low byte, attribute in the high byte.
   // Rows are stored rotated by top_ff so that a scroll only blanks one row.
   logic [CELL_W-1:0] screen_mem [CELLS];

   state_type         state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  line_ff, line_in;
   logic [ROW_W-1:0]  top_ff, top_in;
   logic [ATTR_W-1:0] attr_ff;
   logic [ADDR_W-1:0] sweep_addr_ff, sweep_addr_in;
   logic [ADDR_W-1:0] sweep_last_ff, sweep_last_in;
   logic              sweep_scroll_ff, sweep_scroll_in;
   logic [CELL_W-1:0] rd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // Memory port controls
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;

   // Response load controls
   logic              rsp_load;
   logic              rsp_scroll;
   logic [CHAR_W-1:0] rsp_char;
   logic [ATTR_W-1:0] rsp_attr;

   req_type           req;
   op_type            req_op;
   logic              req_fire;
   logic              put_newline;
   logic              put_wrap;
   logic              put_scroll;
   logic              read_in_range;

   assign req      = req_tdata;
   assign req_op   = op_type'(req_tuser);
   assign req_fire = req_tvalid & req_tready;

   // Take a new item only when idle and the response slot is free or draining.
   assign req_tready = (state_ff == ST_IDLE) & (~rsp_valid_ff | rsp_tready);

   assign put_newline   = (req.char_code == NEWLINE_CHAR);
   assign put_wrap      = put_newline | (col_ff == COL_W'(COLS - 1));
   assign put_scroll    = put_wrap & (line_ff == ROW_W'(ROWS - 1));
   assign read_in_range = (req.cell_row < ROW_W'(ROWS)) & (req.cell_col < COL_W'(COLS));

   //------------------------------------------------------------------
   // Sequencer
   //------------------------------------------------------------------
   always_comb begin
      state_in        = state_ff;
      col_in          = col_ff;
      line_in         = line_ff;
      top_in          = top_ff;
      sweep_addr_in   = sweep_addr_ff;
      sweep_last_in   = sweep_last_ff;
      sweep_scroll_in = sweep_scroll_ff;
      mem_we          = 1'b0;
      mem_waddr       = '0;
      mem_wdata       = '0;
      mem_raddr       = '0;
      rsp_load        = 1'b0;
      rsp_scroll      = 1'b0;
      rsp_char        = '0;
      rsp_attr        = '0;

      unique case (state_ff)
         ST_INIT: begin
            // Post-reset clearing pass with the reset attribute.
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_ff;
            mem_wdata = {RESET_ATTR, BLANK_CHAR};
            if (sweep_addr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               sweep_addr_in = sweep_addr_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_op)
                  OP_PUT: begin
                     // Store the byte at the cursor unless it is a newline.
                     if (!put_newline) begin
                        mem_we    = 1'b1;
                        mem_waddr = cell_addr(phys_row(line_ff, top_ff), col_ff);
                        mem_wdata = {attr_ff, req.char_code};
                     end
                     if (put_wrap) begin
                        col_in = '0;
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                     if (put_scroll) begin
                        // Old top row becomes the new bottom row: rotate, then blank it.
                        top_in          = (top_ff == ROW_W'(ROWS - 1)) ? '0 : top_ff + 1'b1;
                        sweep_addr_in   = cell_addr(top_ff, '0);
                        sweep_last_in   = cell_addr(top_ff, COL_W'(COLS - 1));
                        sweep_scroll_in = 1'b1;
                        state_in        = ST_SWEEP;
                     end else begin
                        if (put_wrap) begin
                           line_in = line_ff + 1'b1;
                        end
                        rsp_load = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     col_in          = '0;
                     line_in         = '0;
                     top_in          = '0;
                     sweep_addr_in   = '0;
                     sweep_last_in   = ADDR_W'(CELLS - 1);
                     sweep_scroll_in = 1'b0;
                     state_in        = ST_SWEEP;
                  end
                  OP_READ: begin
                     if (read_in_range) begin
                        mem_raddr = cell_addr(phys_row(req.cell_row, top_ff), req.cell_col);
                        state_in  = ST_READ;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end

         ST_READ: begin
            // Read data comes from the registered read port, rd_data_ff.
            rsp_load = 1'b1;
            rsp_char = rd_data_ff[CHAR_W-1:0];
            rsp_attr = rd_data_ff[CELL_W-1:CHAR_W];
            state_in = ST_IDLE;
         end

         ST_SWEEP: begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_ff;
            mem_wdata = {attr_ff, BLANK_CHAR};
            if (sweep_addr_ff == sweep_last_ff) begin
               rsp_load   = 1'b1;
               rsp_scroll = sweep_scroll_ff;
               state_in   = ST_IDLE;
            end else begin
               sweep_addr_in = sweep_addr_ff + 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   //------------------------------------------------------------------
   // Response slot
   //------------------------------------------------------------------
   always_comb begin
      rsp_data_in            = rsp_data_ff;
      rsp_valid_in           = rsp_valid_ff & ~rsp_tready;
      if (rsp_load) begin
         rsp_data_in.pad        = '0;
         rsp_data_in.read_attr  = rsp_attr;
         rsp_data_in.read_char  = rsp_char;
         rsp_data_in.did_scroll = rsp_scroll;
         rsp_data_in.cursor_row = line_in;
         rsp_data_in.cursor_col = col_in;
         rsp_valid_in           = 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   //------------------------------------------------------------------
   // Registers
   //------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         col_ff        <= '0;
         line_ff       <= '0;
         top_ff        <= '0;
         attr_ff       <= RESET_ATTR;
         sweep_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         line_ff       <= line_in;
         top_ff        <= top_in;
         sweep_addr_ff <= sweep_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers hold without reset.
   always_ff @(posedge clock) begin
      sweep_last_ff   <= sweep_last_in;
      sweep_scroll_ff <= sweep_scroll_in;
      rsp_data_ff     <= rsp_data_in;
   end

   // Screen memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= screen_mem[mem_raddr];
   end

`ifndef SYNTHESIS
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff < COL_W'(COLS)) && (line_ff < ROW_W'(ROWS)) && (top_ff < ROW_W'(ROWS)))
      else $error("cursor or scroll offset out of screen");

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("response loaded over an untaken transfer");

   a_sweep_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (sweep_addr_ff <= sweep_last_ff))
      else $error("blanking sweep ran past its last cell");

   a_read_follows: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op == OP_READ) && read_in_range) |=>
         (state_ff == ST_READ) && !rsp_valid_ff)
      else $error("cell read did not enter the read wait");

   a_scroll_blanks: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op == OP_PUT) && put_scroll) |=>
         (state_ff == ST_SWEEP) && (line_ff == ROW_W'(ROWS - 1)) && (col_ff == '0))
      else $error("scroll did not start the row blanking");
`endif

endmodule

`default_nettype wire
